// ===== rtl/eight_bit_mcu_instruction_decoder_assert.svh =====
// Assertion macros used by the decoder output stage.
`ifndef EIGHT_BIT_MCU_INSTRUCTION_DECODER_ASSERT_SVH
`define EIGHT_BIT_MCU_INSTRUCTION_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define EMD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define EMD_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define EMD_ASSERT(label, prop)
`define EMD_ASSERT_RST(label, prop)
`endif
`endif

// ===== rtl/emd_pkg.sv =====
// Package with the request and result types and operation codes of the decoder.
package emd_pkg;
    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
    } req_t;

    typedef struct packed {
        logic [6:0]  op_code;
        logic [7:0]  source_byte;
        logic [7:0]  dest_byte;
        logic [15:0] extra_word;
    } res_t;

    typedef struct packed {
        logic [4:0] cls;
        logic [15:0] w;
        logic [15:0] w1;
    } cls_t;

    localparam logic [6:0] OP_UNKNOWN = 7'd0;
    localparam logic [6:0] OP_SLEEP   = 7'd1;
    localparam logic [6:0] OP_RET     = 7'd2;
    localparam logic [6:0] OP_ICALL   = 7'd3;
    localparam logic [6:0] OP_RETI    = 7'd4;
    localparam logic [6:0] OP_IJMP    = 7'd5;
    localparam logic [6:0] OP_WDR     = 7'd6;
    localparam logic [6:0] OP_NOP     = 7'd7;
    localparam logic [6:0] OP_RCALL   = 7'd8;
    localparam logic [6:0] OP_RJMP    = 7'd9;
    localparam logic [6:0] OP_MOVW    = 7'd10;
    localparam logic [6:0] OP_CPC     = 7'd11;
    localparam logic [6:0] OP_SBC     = 7'd12;
    localparam logic [6:0] OP_ADD     = 7'd13;
    localparam logic [6:0] OP_CPSE    = 7'd14;
    localparam logic [6:0] OP_CP      = 7'd15;
    localparam logic [6:0] OP_SUB     = 7'd16;
    localparam logic [6:0] OP_ADC     = 7'd17;
    localparam logic [6:0] OP_AND     = 7'd18;
    localparam logic [6:0] OP_EOR     = 7'd19;
    localparam logic [6:0] OP_OR      = 7'd20;
    localparam logic [6:0] OP_MOV     = 7'd21;
    localparam logic [6:0] OP_OUT     = 7'd22;
    localparam logic [6:0] OP_IN      = 7'd23;
    localparam logic [6:0] OP_LDI     = 7'd24;
    localparam logic [6:0] OP_CPI     = 7'd25;
    localparam logic [6:0] OP_LPM     = 7'd26;
    localparam logic [6:0] OP_BRBS    = 7'd27;
    localparam logic [6:0] OP_BRBC    = 7'd28;
    localparam logic [6:0] OP_LDS     = 7'd29;
    localparam logic [6:0] OP_STS     = 7'd30;
    localparam logic [6:0] OP_LDD     = 7'd31;
    localparam logic [6:0] OP_PUSH    = 7'd32;
    localparam logic [6:0] OP_POP     = 7'd33;
    localparam logic [6:0] OP_LDST    = 7'd34;
    localparam logic [6:0] OP_CALL    = 7'd35;
    localparam logic [6:0] OP_JMP     = 7'd36;
    localparam logic [6:0] OP_SBIW    = 7'd37;
    localparam logic [6:0] OP_ADIW    = 7'd38;
    localparam logic [6:0] OP_SBCI    = 7'd39;
    localparam logic [6:0] OP_SUBI    = 7'd40;
    localparam logic [6:0] OP_ORI     = 7'd41;
    localparam logic [6:0] OP_ANDI    = 7'd42;
    localparam logic [6:0] OP_BSET    = 7'd43;
    localparam logic [6:0] OP_BCLR    = 7'd44;
    localparam logic [6:0] OP_CBI     = 7'd45;
    localparam logic [6:0] OP_SBIC    = 7'd46;
    localparam logic [6:0] OP_SBI     = 7'd47;
    localparam logic [6:0] OP_SBIS    = 7'd48;
    localparam logic [6:0] OP_BLD     = 7'd49;
    localparam logic [6:0] OP_BST     = 7'd50;
    localparam logic [6:0] OP_SBRC    = 7'd51;
    localparam logic [6:0] OP_SBRS    = 7'd52;
    localparam logic [6:0] OP_COM     = 7'd53;
    localparam logic [6:0] OP_NEG     = 7'd54;
    localparam logic [6:0] OP_SWAP    = 7'd55;
    localparam logic [6:0] OP_INC     = 7'd56;
    localparam logic [6:0] OP_ASR     = 7'd57;
    localparam logic [6:0] OP_LSR     = 7'd58;
    localparam logic [6:0] OP_ROR     = 7'd59;
    localparam logic [6:0] OP_DEC     = 7'd60;
    localparam logic [6:0] OP_MUL     = 7'd61;
    localparam logic [6:0] OP_MULS    = 7'd62;
    localparam logic [6:0] OP_MULSU   = 7'd63;
    localparam logic [6:0] OP_FMUL    = 7'd64;
    localparam logic [6:0] OP_FMULS   = 7'd65;
    localparam logic [6:0] OP_FMULSU  = 7'd66;

    localparam logic [4:0] C_NONE  = 5'd0;
    localparam logic [4:0] C_FIXED = 5'd1;
    localparam logic [4:0] C_RJ    = 5'd2;
    localparam logic [4:0] C_MOVW  = 5'd3;
    localparam logic [4:0] C_ALU   = 5'd4;
    localparam logic [4:0] C_IO    = 5'd5;
    localparam logic [4:0] C_LDI   = 5'd6;
    localparam logic [4:0] C_CPI   = 5'd7;
    localparam logic [4:0] C_LPM0  = 5'd8;
    localparam logic [4:0] C_LPM   = 5'd9;
    localparam logic [4:0] C_BR    = 5'd10;
    localparam logic [4:0] C_LDS   = 5'd11;
    localparam logic [4:0] C_STS   = 5'd12;
    localparam logic [4:0] C_LDD   = 5'd13;
    localparam logic [4:0] C_LDST  = 5'd14;
    localparam logic [4:0] C_JMP   = 5'd15;
    localparam logic [4:0] C_ADIW  = 5'd16;
    localparam logic [4:0] C_IMM   = 5'd17;
    localparam logic [4:0] C_BSET  = 5'd18;
    localparam logic [4:0] C_IOBIT = 5'd19;
    localparam logic [4:0] C_RBIT  = 5'd20;
    localparam logic [4:0] C_ONE   = 5'd21;
    localparam logic [4:0] C_MUL   = 5'd22;
    localparam logic [4:0] C_MULS  = 5'd23;
    localparam logic [4:0] C_MULSU = 5'd24;
endpackage

// ===== rtl/emd_classify.sv =====
// First stage: tests the word against the patterns in priority order.
module emd_classify
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  emd_pkg::req_t     in_data,
    input  logic              advance,
    output logic              out_valid,
    output emd_pkg::cls_t     out_data
);
    logic [15:0]   w;
    logic [3:0]    n;
    logic [3:0]    g;
    logic [4:0]    cls_next;
    logic          valid_reg;
    emd_pkg::cls_t data_reg;

    assign w = in_data.first_word;
    assign n = w[3:0];
    assign g = w[13:10];

    always_comb
    begin
        cls_next = emd_pkg::C_NONE;
        if (w == 16'h9588 || w == 16'h9508 || w == 16'h9509 || w == 16'h9518 ||
            w == 16'h9409 || w == 16'h95A8 || w == 16'h0000)
            cls_next = emd_pkg::C_FIXED;
        else if ((w & 16'hE000) == 16'hC000)
            cls_next = emd_pkg::C_RJ;
        else if ((w & 16'hC000) == 16'h0000 && g == 4'd0 && w[9:8] == 2'b01)
            cls_next = emd_pkg::C_MOVW;
        else if ((w & 16'hC000) == 16'h0000 && g != 4'd0 && g <= 4'hB)
            cls_next = emd_pkg::C_ALU;
        else if ((w & 16'hF000) == 16'hB000)
            cls_next = emd_pkg::C_IO;
        else if ((w & 16'hF000) == 16'hE000)
            cls_next = emd_pkg::C_LDI;
        else if ((w & 16'hF000) == 16'h3000)
            cls_next = emd_pkg::C_CPI;
        else if (w == 16'h95C8)
            cls_next = emd_pkg::C_LPM0;
        else if ((w & 16'hFE0E) == 16'h9004)
            cls_next = emd_pkg::C_LPM;
        else if ((w & 16'hF800) == 16'hF000)
            cls_next = emd_pkg::C_BR;
        else if ((w & 16'hFE0F) == 16'h9000)
            cls_next = emd_pkg::C_LDS;
        else if ((w & 16'hFE0F) == 16'h9200)
            cls_next = emd_pkg::C_STS;
        else if ((w & 16'hD000) == 16'h8000)
            cls_next = emd_pkg::C_LDD;
        else if ((w & 16'hFC00) == 16'h9000 && n != 4'd0 && n != 4'd11 &&
                 (n <= 4'd2 || n >= 4'd9))
            cls_next = emd_pkg::C_LDST;
        else if ((w & 16'hFE0C) == 16'h940C)
            cls_next = emd_pkg::C_JMP;
        else if ((w & 16'hFE00) == 16'h9600)
            cls_next = emd_pkg::C_ADIW;
        else if ((w & 16'hC000) == 16'h4000)
            cls_next = emd_pkg::C_IMM;
        else if ((w & 16'hFF0F) == 16'h9408)
            cls_next = emd_pkg::C_BSET;
        else if ((w & 16'hFC00) == 16'h9800)
            cls_next = emd_pkg::C_IOBIT;
        else if ((w & 16'hF808) == 16'hF800)
            cls_next = emd_pkg::C_RBIT;
        else if ((w & 16'hFE00) == 16'h9400 &&
                 (n <= 4'd3 || n == 4'd5 || n == 4'd6 || n == 4'd7 || n == 4'hA))
            cls_next = emd_pkg::C_ONE;
        else if ((w & 16'hFC00) == 16'h9C00)
            cls_next = emd_pkg::C_MUL;
        else if ((w & 16'hFF00) == 16'h0200)
            cls_next = emd_pkg::C_MULS;
        else if ((w & 16'hFF00) == 16'h0300)
            cls_next = emd_pkg::C_MULSU;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg.cls <= cls_next;
            data_reg.w   <= w;
            data_reg.w1  <= in_data.second_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== rtl/emd_extract.sv =====
// Second stage: builds the result fields for the matched class.
module emd_extract
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  emd_pkg::cls_t     in_data,
    input  logic              advance,
    output logic              out_valid,
    output emd_pkg::res_t     out_data
);
    logic [15:0]   w;
    logic [7:0]    imm8;
    logic [7:0]    rhi;
    logic [7:0]    r5;
    logic [7:0]    mask;
    emd_pkg::res_t res_next;
    emd_pkg::res_t data_reg;
    logic          valid_reg;

    assign w    = in_data.w;
    assign imm8 = {w[11:8], w[3:0]};
    assign rhi  = {4'd1, w[7:4]};
    assign r5   = {3'd0, w[8:4]};
    assign mask = 8'd1 << w[2:0];

    always_comb
    begin
        res_next = '0;
        unique case (in_data.cls)
            emd_pkg::C_FIXED:
            begin
                unique case (w)
                    16'h9588: res_next.op_code = emd_pkg::OP_SLEEP;
                    16'h9508: res_next.op_code = emd_pkg::OP_RET;
                    16'h9509: res_next.op_code = emd_pkg::OP_ICALL;
                    16'h9518: res_next.op_code = emd_pkg::OP_RETI;
                    16'h9409: res_next.op_code = emd_pkg::OP_IJMP;
                    16'h95A8: res_next.op_code = emd_pkg::OP_WDR;
                    default:  res_next.op_code = emd_pkg::OP_NOP;
                endcase
            end
            emd_pkg::C_RJ:
            begin
                res_next.op_code    = w[12] ? emd_pkg::OP_RCALL : emd_pkg::OP_RJMP;
                res_next.extra_word = {{4{w[11]}}, w[11:0]};
            end
            emd_pkg::C_MOVW:
            begin
                res_next.op_code     = emd_pkg::OP_MOVW;
                res_next.source_byte = {3'd0, w[9], w[3:0]};
                res_next.dest_byte   = {4'd0, w[7:4]};
            end
            emd_pkg::C_ALU:
            begin
                res_next.op_code     = emd_pkg::OP_MOVW + {3'd0, w[13:10]};
                res_next.source_byte = {3'd0, w[9], w[3:0]};
                res_next.dest_byte   = r5;
            end
            emd_pkg::C_IO:
            begin
                if (w[11])
                begin
                    res_next.op_code     = emd_pkg::OP_OUT;
                    res_next.dest_byte   = {2'd0, w[10:9], w[3:0]};
                    res_next.source_byte = r5;
                end
                else
                begin
                    res_next.op_code     = emd_pkg::OP_IN;
                    res_next.source_byte = {2'd0, w[10:9], w[3:0]};
                    res_next.dest_byte   = r5;
                end
            end
            emd_pkg::C_LDI, emd_pkg::C_CPI:
            begin
                res_next.op_code     = (in_data.cls == emd_pkg::C_LDI) ?
                                       emd_pkg::OP_LDI : emd_pkg::OP_CPI;
                res_next.dest_byte   = rhi;
                res_next.source_byte = imm8;
            end
            emd_pkg::C_LPM0:
            begin
                res_next.op_code    = emd_pkg::OP_LPM;
                res_next.extra_word = 16'd2;
            end
            emd_pkg::C_LPM:
            begin
                res_next.op_code    = emd_pkg::OP_LPM;
                res_next.dest_byte  = r5;
                res_next.extra_word = {15'd0, w[0]};
            end
            emd_pkg::C_BR:
            begin
                res_next.op_code     = w[10] ? emd_pkg::OP_BRBC : emd_pkg::OP_BRBS;
                res_next.source_byte = {5'd0, w[2:0]};
                res_next.extra_word  = {{9{w[9]}}, w[9:3]};
            end
            emd_pkg::C_LDS:
            begin
                res_next.op_code    = emd_pkg::OP_LDS;
                res_next.dest_byte  = r5;
                res_next.extra_word = in_data.w1;
            end
            emd_pkg::C_STS:
            begin
                res_next.op_code     = emd_pkg::OP_STS;
                res_next.source_byte = r5;
                res_next.extra_word  = in_data.w1;
            end
            emd_pkg::C_LDD:
            begin
                res_next.op_code     = emd_pkg::OP_LDD;
                res_next.source_byte = r5;
                res_next.dest_byte   = {2'd0, w[13], w[11:10], w[2:0]};
                res_next.extra_word  = w & 16'h0208;
            end
            emd_pkg::C_LDST:
            begin
                res_next.source_byte = r5;
                res_next.dest_byte   = {4'd0, w[3:0]};
                res_next.extra_word  = w & 16'h0200;
                if (w[3:0] == 4'hF)
                    res_next.op_code = w[9] ? emd_pkg::OP_PUSH : emd_pkg::OP_POP;
                else
                    res_next.op_code = emd_pkg::OP_LDST;
            end
            emd_pkg::C_JMP:
            begin
                res_next.op_code    = w[1] ? emd_pkg::OP_CALL : emd_pkg::OP_JMP;
                res_next.extra_word = in_data.w1 & 16'h3FFF;
            end
            emd_pkg::C_ADIW:
            begin
                res_next.op_code     = w[8] ? emd_pkg::OP_SBIW : emd_pkg::OP_ADIW;
                res_next.dest_byte   = 8'd24 + {5'd0, w[5:4], 1'b0};
                res_next.source_byte = {2'd0, w[7:6], w[3:0]};
            end
            emd_pkg::C_IMM:
            begin
                res_next.op_code     = emd_pkg::OP_SBCI + {5'd0, w[13:12]};
                res_next.source_byte = imm8;
                res_next.dest_byte   = rhi;
            end
            emd_pkg::C_BSET:
            begin
                res_next.source_byte = {5'd0, w[6:4]};
                if (w[7])
                begin
                    res_next.op_code   = emd_pkg::OP_BCLR;
                    res_next.dest_byte = ~(8'd1 << w[6:4]);
                end
                else
                begin
                    res_next.op_code   = emd_pkg::OP_BSET;
                    res_next.dest_byte = 8'd1 << w[6:4];
                end
            end
            emd_pkg::C_IOBIT:
            begin
                res_next.op_code     = emd_pkg::OP_CBI + {5'd0, w[9:8]};
                res_next.dest_byte   = {3'd0, w[7:3]};
                res_next.source_byte = mask;
            end
            emd_pkg::C_RBIT:
            begin
                res_next.op_code     = emd_pkg::OP_BLD + {5'd0, w[10:9]};
                res_next.dest_byte   = r5;
                res_next.source_byte = mask;
            end
            emd_pkg::C_ONE:
            begin
                res_next.dest_byte = r5;
                case (w[3:0])
                    4'h0:    res_next.op_code = emd_pkg::OP_COM;
                    4'h1:    res_next.op_code = emd_pkg::OP_NEG;
                    4'h2:    res_next.op_code = emd_pkg::OP_SWAP;
                    4'h3:    res_next.op_code = emd_pkg::OP_INC;
                    4'h5:    res_next.op_code = emd_pkg::OP_ASR;
                    4'h6:    res_next.op_code = emd_pkg::OP_LSR;
                    4'h7:    res_next.op_code = emd_pkg::OP_ROR;
                    default: res_next.op_code = emd_pkg::OP_DEC;
                endcase
            end
            emd_pkg::C_MUL:
            begin
                res_next.op_code     = emd_pkg::OP_MUL;
                res_next.dest_byte   = r5;
                res_next.source_byte = {3'd0, w[9], w[3:0]};
            end
            emd_pkg::C_MULS:
            begin
                res_next.op_code     = emd_pkg::OP_MULS;
                res_next.dest_byte   = rhi;
                res_next.source_byte = {4'd1, w[3:0]};
            end
            emd_pkg::C_MULSU:
            begin
                res_next.op_code     = emd_pkg::OP_MULSU + {5'd0, w[7], w[3]};
                res_next.dest_byte   = {5'd2, w[6:4]};
                res_next.source_byte = {5'd2, w[2:0]};
            end
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== rtl/emd_out.sv =====
// Output stage: holds the finished result until it is taken.
module emd_out
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  emd_pkg::res_t     in_data,
    input  logic              advance,
    output logic              out_valid,
    output emd_pkg::res_t     out_data
);
    logic          valid_reg;
    emd_pkg::res_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= in_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`include "eight_bit_mcu_instruction_decoder_assert.svh"
    `EMD_ASSERT(a_known_code, valid_reg |-> (data_reg.op_code <= 7'd66))
    `EMD_ASSERT(a_unknown_clear, (valid_reg && data_reg.op_code == emd_pkg::OP_UNKNOWN) |-> (data_reg.source_byte == 8'd0 && data_reg.extra_word == 16'd0))
    `EMD_ASSERT(a_hold, (valid_reg && !advance) |=> (valid_reg && $stable(data_reg)))
endmodule

// ===== rtl/eight_bit_mcu_instruction_decoder.sv =====
// Top level of the instruction predecoder: three register stages.
// Each request (an opcode word and the word after it) gives one result that
// passes the classify, extract and output registers in turn. A new request may
// be accepted in every cycle without a stall; the three stages move together
// and are held only while the output holds a stalled result; the input stalls then.
module eight_bit_mcu_instruction_decoder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  emd_pkg::req_t     in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output emd_pkg::res_t     out_data
);
    logic          advance;
    logic          s1_valid;
    logic          s2_valid;
    emd_pkg::cls_t s1_data;
    emd_pkg::res_t s2_data;

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    emd_classify u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .advance   (advance),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    emd_extract u_extract
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .advance   (advance),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    emd_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .advance   (advance),
        .out_valid (out_valid),
        .out_data  (out_data)
    );
endmodule
